[hdl/avgpw_pkg.sv]
// Shared types and constants for the average pooling window block.
// No dependencies; every other file of the block but avgpw_ram imports this package.
package avgpw_pkg;

    localparam int MAX_KERNEL   = 8;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_HEIGHT   = 256;
    localparam int SAMPLE_W     = 16;

    localparam int KERN_W   = 4;
    localparam int STRIDE_W = 4;
    localparam int DIM_W    = 9;
    localparam int CHCFG_W  = 7;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 3;

    localparam int ROW_W  = 8;
    localparam int COL_W  = 8;
    localparam int CH_W   = 6;
    localparam int KIDX_W = $clog2(MAX_KERNEL);

    localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int ACC_W  = SAMPLE_W + 2 * KIDX_W;
    localparam int DIV_W  = 7;
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] POS_LAST = STEP_W'(ROW_W - 1);
    localparam logic [STEP_W-1:0] SUM_LAST = STEP_W'(ACC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL   = 3'd0,
        CFG_STRIDE_R = 3'd1,
        CFG_STRIDE_C = 3'd2,
        CFG_HEIGHT   = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_CHANNELS = 3'd5,
        CFG_LAYOUT   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [KERN_W-1:0]   kernel;
        logic [STRIDE_W-1:0] stride_r;
        logic [STRIDE_W-1:0] stride_c;
        logic [DIM_W-1:0]    height;
        logic [DIM_W-1:0]    width;
        logic [CHCFG_W-1:0]  chans;
        logic                layout;
        logic [DIV_W-1:0]    area;
    } cfg_t;

    typedef enum logic [2:0] {
        ARITH_NOP      = 3'd0,
        ARITH_CLEAR    = 3'd1,
        ARITH_ACCUM    = 3'd2,
        ARITH_LOAD_EXT = 3'd3,
        ARITH_LOAD_ACC = 3'd4,
        ARITH_STEP     = 3'd5
    } arith_op_t;

    typedef struct packed {
        arith_op_t                  op;
        logic [ACC_W-1:0]           dividend;
        logic [DIV_W-1:0]           divisor;
        logic signed [SAMPLE_W-1:0] data;
    } arith_cmd_t;

    typedef struct packed {
        logic [ACC_W-1:0] quotient;
        logic             negative;
        logic             rem_zero;
    } arith_stat_t;

endpackage

[hdl/avgpw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the line store of the pooling block.
module avgpw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/avgpw_arith.sv]
// Shared arithmetic unit: one adder serves window accumulation, magnitude
// and restoring division steps. Depends on avgpw_pkg.
module avgpw_arith
    import avgpw_pkg::*;
(
    input  logic        clk,
    input  arith_cmd_t  cmd,
    output arith_stat_t stat
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic             neg_reg, neg_next;

    logic [ACC_W+1:0] add_a, add_b, add_y;
    logic             add_sub;
    logic [ACC_W:0]   trial;

    assign trial = {acc_reg, quo_reg[ACC_W-1]};
    assign add_y = add_a + (add_sub ? ~add_b : add_b) + {{(ACC_W+1){1'b0}}, add_sub};

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (cmd.op)
            ARITH_ACCUM:
            begin
                add_a = {{2{acc_reg[ACC_W-1]}}, acc_reg};
                add_b = {{(ACC_W+2-SAMPLE_W){cmd.data[SAMPLE_W-1]}}, cmd.data};
            end
            ARITH_LOAD_ACC:
            begin
                add_b   = {{2{acc_reg[ACC_W-1]}}, acc_reg};
                add_sub = acc_reg[ACC_W-1];
            end
            ARITH_STEP:
            begin
                add_a   = {1'b0, trial};
                add_b   = {{(ACC_W+2-DIV_W){1'b0}}, dsr_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        neg_next = neg_reg;
        case (cmd.op)
            ARITH_CLEAR:
            begin
                acc_next = '0;
            end
            ARITH_ACCUM:
            begin
                acc_next = add_y[ACC_W-1:0];
            end
            ARITH_LOAD_EXT:
            begin
                quo_next = cmd.dividend;
                acc_next = '0;
                dsr_next = cmd.divisor;
                neg_next = 1'b0;
            end
            ARITH_LOAD_ACC:
            begin
                quo_next = add_y[ACC_W-1:0];
                acc_next = '0;
                dsr_next = cmd.divisor;
                neg_next = acc_reg[ACC_W-1];
            end
            ARITH_STEP:
            begin
                if (add_y[ACC_W+1])
                begin
                    acc_next = trial[ACC_W-1:0];
                    quo_next = {quo_reg[ACC_W-2:0], 1'b0};
                end
                else
                begin
                    acc_next = add_y[ACC_W-1:0];
                    quo_next = {quo_reg[ACC_W-2:0], 1'b1};
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign stat.quotient = quo_reg;
    assign stat.negative = neg_reg;
    assign stat.rem_zero = (acc_reg == '0);

endmodule

[hdl/avgpw_seq.sv]
// Sequencer: position counters, stride checks, window reads and the output
// register. Depends on avgpw_pkg and drives avgpw_arith and the line store.
module avgpw_seq
    import avgpw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       frame_start,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] average,
    output logic [ROW_W-1:0]           out_row,
    output logic [COL_W-1:0]           out_col,
    output logic [CH_W-1:0]            out_channel,
    output logic                       ram_wr_en,
    output logic [ADDR_W-1:0]          ram_wr_addr,
    output logic                       ram_rd_en,
    output logic [ADDR_W-1:0]          ram_rd_addr,
    input  logic [SAMPLE_W-1:0]        ram_rd_data,
    output arith_cmd_t                 cmd,
    input  arith_stat_t                stat
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_ROW_LOAD = 13'b0000000000010,
        S_ROW_DIV  = 13'b0000000000100,
        S_ROW_CHK  = 13'b0000000001000,
        S_COL_LOAD = 13'b0000000010000,
        S_COL_DIV  = 13'b0000000100000,
        S_COL_CHK  = 13'b0000001000000,
        S_CLEAR    = 13'b0000010000000,
        S_READ     = 13'b0000100000000,
        S_DRAIN    = 13'b0001000000000,
        S_SUM_LOAD = 13'b0010000000000,
        S_SUM_DIV  = 13'b0100000000000,
        S_EMIT     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [CH_W-1:0]   ch_cnt_reg, ch_cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [KIDX_W-1:0] ki_reg, ki_next;
    logic [KIDX_W-1:0] kj_reg, kj_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              out_valid_reg, out_valid_next;

    logic [ROW_W-1:0]           r0_reg;
    logic [COL_W-1:0]           c0_reg;
    logic [CH_W-1:0]            cur_ch_reg;
    logic [ROW_W-1:0]           orow_reg;
    logic [COL_W-1:0]           ocol_reg;
    logic signed [SAMPLE_W-1:0] average_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic [CH_W-1:0]            out_ch_reg;

    logic              accept;
    logic              emit_fire;
    logic              window_ok;
    logic              last_tap;
    logic [ROW_W-1:0]  base_r;
    logic [COL_W-1:0]  base_c;
    logic [CH_W-1:0]   base_ch;
    logic [DIM_W-1:0]  nr, ncl;
    logic [CHCFG_W-1:0] nch;
    logic [KIDX_W-1:0] km1;
    logic [KIDX_W-1:0] tap_row;
    logic [COL_W-1:0]  tap_col;
    logic [SAMPLE_W-1:0] avg_mag;
    logic [SAMPLE_W-1:0] avg_val;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign base_r  = frame_start ? '0 : row_cnt_reg;
    assign base_c  = frame_start ? '0 : col_cnt_reg;
    assign base_ch = frame_start ? '0 : ch_cnt_reg;

    assign window_ok = (({1'b0, base_r} + 9'd1) >= {5'b0, cfg.kernel})
                    && (({1'b0, base_c} + 9'd1) >= {5'b0, cfg.kernel});

    always_comb
    begin
        nr  = {1'b0, base_r};
        ncl = {1'b0, base_c};
        nch = {1'b0, base_ch};
        if (!cfg.layout)
        begin
            nch = nch + 7'd1;
            if (nch >= cfg.chans)
            begin
                nch = '0;
                ncl = ncl + 9'd1;
                if (ncl >= cfg.width)
                begin
                    ncl = '0;
                    nr  = nr + 9'd1;
                    if (nr >= cfg.height)
                    begin
                        nr = '0;
                    end
                end
            end
        end
        else
        begin
            ncl = ncl + 9'd1;
            if (ncl >= cfg.width)
            begin
                ncl = '0;
                nr  = nr + 9'd1;
                if (nr >= cfg.height)
                begin
                    nr  = '0;
                    nch = nch + 7'd1;
                    if (nch >= cfg.chans)
                    begin
                        nch = '0;
                    end
                end
            end
        end
        if (nch >= cfg.chans)
        begin
            nch = '0;
        end
        if (ncl >= cfg.width)
        begin
            ncl = '0;
        end
        if (nr >= cfg.height)
        begin
            nr = '0;
        end
    end

    assign km1      = KIDX_W'(cfg.kernel - 4'd1);
    assign last_tap = (ki_reg == km1) && (kj_reg == km1);
    assign tap_row  = r0_reg[KIDX_W-1:0] + ki_reg;
    assign tap_col  = c0_reg + {{(COL_W-KIDX_W){1'b0}}, kj_reg};

    assign ram_wr_en   = accept;
    assign ram_wr_addr = {base_r[KIDX_W-1:0], base_c, base_ch};
    assign ram_rd_en   = (state_reg == S_READ);
    assign ram_rd_addr = {tap_row, tap_col, cur_ch_reg};

    assign avg_mag = stat.quotient[SAMPLE_W-1:0];
    assign avg_val = stat.negative ? SAMPLE_W'(~avg_mag + 1'b1) : avg_mag;

    always_comb
    begin
        cmd.op       = ARITH_NOP;
        cmd.dividend = {r0_reg, {(ACC_W-ROW_W){1'b0}}};
        cmd.divisor  = {{(DIV_W-STRIDE_W){1'b0}}, cfg.stride_r};
        cmd.data     = ram_rd_data;
        unique case (state_reg)
            S_ROW_LOAD:
            begin
                cmd.op = ARITH_LOAD_EXT;
            end
            S_COL_LOAD:
            begin
                cmd.op       = ARITH_LOAD_EXT;
                cmd.dividend = {c0_reg, {(ACC_W-COL_W){1'b0}}};
                cmd.divisor  = {{(DIV_W-STRIDE_W){1'b0}}, cfg.stride_c};
            end
            S_ROW_DIV, S_COL_DIV, S_SUM_DIV:
            begin
                cmd.op = ARITH_STEP;
            end
            S_CLEAR:
            begin
                cmd.op = ARITH_CLEAR;
            end
            S_READ:
            begin
                cmd.op = rd_pend_reg ? ARITH_ACCUM : ARITH_NOP;
            end
            S_DRAIN:
            begin
                cmd.op = ARITH_ACCUM;
            end
            S_SUM_LOAD:
            begin
                cmd.op      = ARITH_LOAD_ACC;
                cmd.divisor = cfg.area;
            end
            S_IDLE, S_ROW_CHK, S_COL_CHK, S_EMIT:
            begin
                cmd.op = ARITH_NOP;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        ch_cnt_next    = ch_cnt_reg;
        step_next      = step_reg;
        ki_next        = ki_reg;
        kj_next        = kj_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_cnt_next = nr[ROW_W-1:0];
                    col_cnt_next = ncl[COL_W-1:0];
                    ch_cnt_next  = nch[CH_W-1:0];
                    if (window_ok)
                    begin
                        state_next = S_ROW_LOAD;
                    end
                end
            end
            S_ROW_LOAD, S_COL_LOAD, S_SUM_LOAD:
            begin
                step_next = '0;
                if (state_reg == S_ROW_LOAD)
                begin
                    state_next = S_ROW_DIV;
                end
                else if (state_reg == S_COL_LOAD)
                begin
                    state_next = S_COL_DIV;
                end
                else
                begin
                    state_next = S_SUM_DIV;
                end
            end
            S_ROW_DIV:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == POS_LAST)
                begin
                    state_next = S_ROW_CHK;
                end
            end
            S_COL_DIV:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == POS_LAST)
                begin
                    state_next = S_COL_CHK;
                end
            end
            S_ROW_CHK:
            begin
                state_next = stat.rem_zero ? S_COL_LOAD : S_IDLE;
            end
            S_COL_CHK:
            begin
                state_next = stat.rem_zero ? S_CLEAR : S_IDLE;
            end
            S_CLEAR:
            begin
                ki_next    = '0;
                kj_next    = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                rd_pend_next = 1'b1;
                if (kj_reg == km1)
                begin
                    kj_next = '0;
                    ki_next = ki_reg + 3'd1;
                end
                else
                begin
                    kj_next = kj_reg + 3'd1;
                end
                if (last_tap)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SUM_LOAD;
            end
            S_SUM_DIV:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == SUM_LAST)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            ch_cnt_reg    <= '0;
            step_reg      <= '0;
            ki_reg        <= '0;
            kj_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            ch_cnt_reg    <= ch_cnt_next;
            step_reg      <= step_next;
            ki_reg        <= ki_next;
            kj_reg        <= kj_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r0_reg     <= base_r + 8'd1 - {4'b0, cfg.kernel};
            c0_reg     <= base_c + 8'd1 - {4'b0, cfg.kernel};
            cur_ch_reg <= base_ch;
        end
        if (state_reg == S_ROW_CHK)
        begin
            orow_reg <= stat.quotient[ROW_W-1:0];
        end
        if (state_reg == S_COL_CHK)
        begin
            ocol_reg <= stat.quotient[COL_W-1:0];
        end
        if (emit_fire)
        begin
            average_reg <= avg_val;
            out_row_reg <= orow_reg;
            out_col_reg <= ocol_reg;
            out_ch_reg  <= cur_ch_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign average     = average_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_channel = out_ch_reg;

endmodule

[hdl/average_pooling_window.sv]
// Top level of the streaming 2-D average pooling block: configuration
// registers, line store, shared arithmetic unit and sequencer.
// Depends on avgpw_pkg, avgpw_ram, avgpw_arith and avgpw_seq.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_stall  sample, frame_start
//   output    out_valid / out_stall average, out_row, out_col, out_channel
//   config    cfg_wr_en            cfg_index, cfg_data
//
// A beat that completes no window leaves the block idle; one that fails the row or
// column stride test returns to idle after that stride division.
// A beat that completes a window reads its taps through the single read
// port of the line store and divides their sum one bit per cycle.
// The line store has no reset and no clearing pass; counters reset to zero.
// A finished result waits in the output register while out_stall is high.
module average_pooling_window
    import avgpw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       frame_start,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] average,
    output logic [ROW_W-1:0]           out_row,
    output logic [COL_W-1:0]           out_col,
    output logic [CH_W-1:0]            out_channel
);

    logic [KERN_W-1:0]   kernel_reg;
    logic [STRIDE_W-1:0] stride_r_reg;
    logic [STRIDE_W-1:0] stride_c_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [CHCFG_W-1:0]  chans_reg;
    logic                layout_reg;

    cfg_t              cfg;
    logic [2*KERN_W-1:0] area_full;
    arith_cmd_t        cmd;
    arith_stat_t       stat;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [SAMPLE_W-1:0] ram_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg   <= 4'd2;
            stride_r_reg <= 4'd2;
            stride_c_reg <= 4'd2;
            height_reg   <= 9'd32;
            width_reg    <= 9'd32;
            chans_reg    <= 7'd1;
            layout_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_KERNEL:   kernel_reg   <= cfg_data[KERN_W-1:0];
                CFG_STRIDE_R: stride_r_reg <= cfg_data[STRIDE_W-1:0];
                CFG_STRIDE_C: stride_c_reg <= cfg_data[STRIDE_W-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[DIM_W-1:0];
                CFG_WIDTH:    width_reg    <= cfg_data[DIM_W-1:0];
                CFG_CHANNELS: chans_reg    <= cfg_data[CHCFG_W-1:0];
                CFG_LAYOUT:   layout_reg   <= cfg_data[0];
                default:      layout_reg   <= layout_reg;
            endcase
        end
    end

    always_comb
    begin
        if (kernel_reg == '0)
        begin
            cfg.kernel = 4'd1;
        end
        else if (kernel_reg > KERN_W'(MAX_KERNEL))
        begin
            cfg.kernel = KERN_W'(MAX_KERNEL);
        end
        else
        begin
            cfg.kernel = kernel_reg;
        end
        cfg.stride_r = (stride_r_reg == '0) ? 4'd1 : stride_r_reg;
        cfg.stride_c = (stride_c_reg == '0) ? 4'd1 : stride_c_reg;
        if (height_reg == '0)
        begin
            cfg.height = 9'd1;
        end
        else if (height_reg > DIM_W'(MAX_HEIGHT))
        begin
            cfg.height = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            cfg.height = height_reg;
        end
        if (width_reg == '0)
        begin
            cfg.width = 9'd1;
        end
        else if (width_reg > DIM_W'(MAX_WIDTH))
        begin
            cfg.width = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = width_reg;
        end
        if (chans_reg == '0)
        begin
            cfg.chans = 7'd1;
        end
        else if (chans_reg > CHCFG_W'(MAX_CHANNELS))
        begin
            cfg.chans = CHCFG_W'(MAX_CHANNELS);
        end
        else
        begin
            cfg.chans = chans_reg;
        end
        cfg.layout = layout_reg;
        area_full  = cfg.kernel * cfg.kernel;
        cfg.area   = area_full[DIV_W-1:0];
    end

    avgpw_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (sample),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    avgpw_arith u_arith (
        .clk  (clk),
        .cmd  (cmd),
        .stat (stat)
    );

    avgpw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .average     (average),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_channel (out_channel),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

[hdl/avgpw_checker.sv]
// Port-level assertions for the average pooling window block, with the bind
// that attaches them to the top level. Depends on avgpw_pkg.
module avgpw_checker
    import avgpw_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [SAMPLE_W-1:0] average,
    input logic [ROW_W-1:0]           out_row,
    input logic [COL_W-1:0]           out_col,
    input logic [CH_W-1:0]            out_channel
);

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(average)
            && $stable(out_row) && $stable(out_col) && $stable(out_channel)))
    else $error("stalled output beat changed");

    // No result is shown while the block is held in reset.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("output valid during reset");

    // A new result appears only right after the input was held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a busy cycle");

    // A result taken is followed by another only if the block was busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (!out_valid || $past(in_stall)))
    else $error("back-to-back result without a busy cycle");

endmodule

bind average_pooling_window avgpw_checker u_checker (.*);

[sim/tb_average_pooling_window.sv]
// Self-checking testbench for average_pooling_window: random and directed sample streams
// under several window, stride, size and layout settings, checked against a built-in predictor.
// Depends on avgpw_pkg and the average_pooling_window RTL.
module tb_average_pooling_window;
    import avgpw_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] average;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic [CH_W-1:0]            chan;
    } window_t;

    class window_average_board;
        logic [KERN_W-1:0]          kernel;
        logic [STRIDE_W-1:0]        stride_r;
        logic [STRIDE_W-1:0]        stride_c;
        logic [DIM_W-1:0]           height;
        logic [DIM_W-1:0]           width;
        logic [CHCFG_W-1:0]         chans;
        logic                       layout;
        logic signed [SAMPLE_W-1:0] line_mem [STORE_DEPTH];
        int unsigned                row_pos;
        int unsigned                col_pos;
        int unsigned                chan_pos;
        window_t                    windows_due [$];
        int unsigned                errors;

        function new();
            kernel = 2;
            stride_r = 2;
            stride_c = 2;
            height = 32;
            width = 32;
            chans = 1;
            layout = 1'b0;
            row_pos = 0;
            col_pos = 0;
            chan_pos = 0;
            errors = 0;
        endfunction

        function int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo)
            begin
                return lo;
            end
            if (v > hi)
            begin
                return hi;
            end
            return v;
        endfunction

        function int unsigned store_addr(int unsigned r, int unsigned c, int unsigned ch);
            return (((r % MAX_KERNEL) * MAX_WIDTH + (c % MAX_WIDTH)) * MAX_CHANNELS)
                   + (ch % MAX_CHANNELS);
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_KERNEL:   kernel = value[KERN_W-1:0];
                CFG_STRIDE_R: stride_r = value[STRIDE_W-1:0];
                CFG_STRIDE_C: stride_c = value[STRIDE_W-1:0];
                CFG_HEIGHT:   height = value[DIM_W-1:0];
                CFG_WIDTH:    width = value[DIM_W-1:0];
                CFG_CHANNELS: chans = value[CHCFG_W-1:0];
                CFG_LAYOUT:   layout = value[0];
                default:      ;
            endcase
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] value, logic first);
            int unsigned k;
            int unsigned sr;
            int unsigned sc;
            int unsigned h;
            int unsigned w;
            int unsigned nc;
            int unsigned r;
            int unsigned c;
            int unsigned ch;
            int unsigned r0;
            int unsigned c0;
            int          total;
            window_t     win;
            k = bound(kernel, 1, MAX_KERNEL);
            sr = (stride_r == 0) ? 1 : stride_r;
            sc = (stride_c == 0) ? 1 : stride_c;
            h = bound(height, 1, MAX_HEIGHT);
            w = bound(width, 1, MAX_WIDTH);
            nc = bound(chans, 1, MAX_CHANNELS);
            if (first)
            begin
                row_pos = 0;
                col_pos = 0;
                chan_pos = 0;
            end
            r = row_pos;
            c = col_pos;
            ch = chan_pos;
            line_mem[store_addr(r, c, ch)] = value;
            if (r + 1 >= k && c + 1 >= k)
            begin
                r0 = r + 1 - k;
                c0 = c + 1 - k;
                if (r0 % sr == 0 && c0 % sc == 0)
                begin
                    total = 0;
                    for (int i = 0; i < k; i++)
                    begin
                        for (int j = 0; j < k; j++)
                        begin
                            total += line_mem[store_addr(r0 + i, c0 + j, ch)];
                        end
                    end
                    win.average = SAMPLE_W'(total / int'(k * k));
                    win.row = ROW_W'(r0 / sr);
                    win.col = COL_W'(c0 / sc);
                    win.chan = CH_W'(ch);
                    windows_due.push_back(win);
                end
            end
            if (!layout)
            begin
                ch++;
                if (ch >= nc)
                begin
                    ch = 0;
                    c++;
                    if (c >= w)
                    begin
                        c = 0;
                        r++;
                        if (r >= h)
                        begin
                            r = 0;
                        end
                    end
                end
            end
            else
            begin
                c++;
                if (c >= w)
                begin
                    c = 0;
                    r++;
                    if (r >= h)
                    begin
                        r = 0;
                        ch++;
                        if (ch >= nc)
                        begin
                            ch = 0;
                        end
                    end
                end
            end
            if (ch >= nc)
            begin
                ch = 0;
            end
            if (c >= w)
            begin
                c = 0;
            end
            if (r >= h)
            begin
                r = 0;
            end
            row_pos = r;
            col_pos = c;
            chan_pos = ch;
        endfunction

        function void check_window(logic signed [SAMPLE_W-1:0] avg, logic [ROW_W-1:0] row,
                                   logic [COL_W-1:0] col, logic [CH_W-1:0] chan);
            window_t want;
            if (windows_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result: average %0d row %0d col %0d channel %0d",
                             avg, row, col, chan);
                end
            end
            else
            begin
                want = windows_due.pop_front();
                if (want.average !== avg || want.row !== row || want.col !== col
                    || want.chan !== chan)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: expected average %0d row %0d col %0d channel %0d",
                                 want.average, want.row, want.col, want.chan);
                        $display("          got      average %0d row %0d col %0d channel %0d",
                                 avg, row, col, chan);
                    end
                end
            end
        endfunction

        function int unsigned pending();
            return windows_due.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_start;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] average;
    logic [ROW_W-1:0]           out_row;
    logic [COL_W-1:0]           out_col;
    logic [CH_W-1:0]            out_channel;

    window_average_board pool;
    int unsigned         sent_beats = 0;
    int unsigned         windows_seen = 0;
    int unsigned         hold_left = 0;
    bit                  hold_request = 1'b0;
    bit                  hold_done = 1'b0;

    average_pooling_window i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .average     (average),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_channel (out_channel)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        pool.set_reg(idx, CFG_W'(value));
    endtask

    task automatic configure(input int unsigned k, input int unsigned sr, input int unsigned sc,
                             input int unsigned h, input int unsigned w, input int unsigned nc,
                             input int unsigned lay);
        in_valid <= 1'b0;
        while (pool.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);
        write_reg(CFG_KERNEL, k);
        write_reg(CFG_STRIDE_R, sr);
        write_reg(CFG_STRIDE_C, sc);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_CHANNELS, nc);
        write_reg(CFG_LAYOUT, lay);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_beat(input logic signed [SAMPLE_W-1:0] value, input logic first);
        logic taken;
        while (!(sent_beats >= 600 && sent_beats < 900) && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        frame_start <= first;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        pool.take_sample(value, first);
        sent_beats++;
    endtask

    task automatic send_images(input int unsigned count, input int unsigned img,
                               input bit noisy);
        logic                       first;
        logic signed [SAMPLE_W-1:0] value;
        for (int unsigned i = 0; i < count; i++)
        begin
            first = (i == 0) || (i % img == 0 && $urandom_range(1) == 1)
                    || (noisy && $urandom_range(63) == 0);
            if ($urandom_range(7) == 0)
            begin
                value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            else
            begin
                value = SAMPLE_W'($urandom);
            end
            send_beat(value, first);
        end
    endtask

    initial
    begin
        int unsigned k;
        int unsigned h;
        int unsigned w;
        int unsigned nc;
        int unsigned img;
        int unsigned count;
        pool = new();
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_KERNEL;
        cfg_data <= '0;
        in_valid <= 1'b0;
        sample <= '0;
        frame_start <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Saturated windows, wrap into a second image without a frame mark,
        // then small negative sums that must round toward zero.
        configure(2, 1, 1, 3, 3, 1, 0);
        for (int i = 0; i < 9; i++)
        begin
            send_beat(16'sh7FFF, i == 0);
        end
        for (int i = 0; i < 9; i++)
        begin
            send_beat(16'sh8000, 1'b0);
        end
        send_beat(-16'sd1, 1'b1);
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sd3, 1'b0);
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sd0, 1'b0);
        send_beat(16'sd3, 1'b0);

        // Registers out of range in both directions.
        configure(0, 0, 0, 0, 0, 0, 1);
        send_images(20, 1, 1'b0);
        configure(15, 15, 9, 9, 9, 1, 0);
        send_images(81, 81, 1'b0);

        configure(8, 8, 8, 8, 16, 1, 1);
        send_images(128, 128, 1'b0);
        configure(8, 1, 1, 9, 9, 1, 0);
        send_images(81, 81, 1'b0);

        configure(1, 1, 1, 9'h1FF, 1, 1, 0);
        hold_request = 1'b1;
        send_images(258, 256, 1'b0);
        configure(1, 1, 2, 2, 300, 1, 1);
        send_images(258, 512, 1'b0);
        configure(1, 1, 1, 1, 2, 127, 0);
        send_images(130, 128, 1'b0);
        configure(1, 1, 1, 1, 1, 64, 1);
        send_images(66, 64, 1'b0);

        while (sent_beats < 1550)
        begin
            k = ($urandom_range(5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            h = $urandom_range(k, k + 4);
            w = $urandom_range(k, k + 6);
            nc = $urandom_range(1, 2);
            img = h * w * nc;
            count = img;
            if ($urandom_range(2) == 0)
            begin
                count += $urandom_range(1, img);
            end
            if (sent_beats + count > 1600)
            begin
                count = 1600 - sent_beats;
            end
            configure(k, $urandom_range(1, 3), $urandom_range(1, 3), h, w, nc,
                      $urandom_range(1));
            send_images(count, img, $urandom_range(3) == 0);
        end

        in_valid <= 1'b0;
        while (pool.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);
        if (pool.errors == 0)
        begin
            $display("average_pooling_window test passed");
        end
        else
        begin
            $display("average_pooling_window test failed");
        end
        $finish;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 2000;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= (windows_seen < 250 || windows_seen >= 400)
                             && ($urandom_range(99) < 13);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            pool.check_window(average, out_row, out_col, out_channel);
            windows_seen++;
        end
    end

    initial
    begin
        #24_000_000;
        $display("average_pooling_window test failed");
        $finish;
    end

endmodule
